[rtl/sae_pkg.sv]
// ============================================================================
// sae_pkg: shared definitions for the sorted array engine
// Field widths, capacity, command and status codes, and the control structs
// that join the controller to the datapath.
// ============================================================================
package sae_pkg;

    // Storage geometry
    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Result field widths
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 6;

    // Command codes
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture the accepted item
        logic scan;      // one step of the linear insert/remove pass
        logic srch_rd;   // issue the read of the bisection midpoint
        logic srch_cmp;  // compare the midpoint entry and narrow the range
        logic res_load;  // load the result register and commit the count
    } sae_dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] cmd;       // command of the item at work
        logic       full;      // store full when the item was taken
        logic       empty;     // store empty
        logic       scan_last; // the last slot of the pass is being handled
        logic       srch_done; // bisection range is empty
        logic       srch_hit;  // midpoint entry equals the operand
        logic       out_busy;  // result register holds an item not yet taken
    } sae_dp_sts_t;

endpackage

[rtl/sae_if.sv]
// ============================================================================
// sae_if: channel interfaces of the sorted array engine
// Request, response and configuration channels, each with valid and ready.
// ============================================================================

// Request channel: one command item
interface sae_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

// Response channel: one result item
interface sae_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [4:0] position;
    logic [5:0] count;

    modport source (output valid, output status, output position, output count,
                    input ready);
    modport sink   (input valid, input status, input position, input count,
                    output ready);
endinterface

// Configuration channel: write of the order register
interface sae_cfg_if;
    logic valid;
    logic ready;
    logic descending;

    modport source (output valid, output descending, input ready);
    modport sink   (input valid, input descending, output ready);
endinterface

[rtl/sorted_array_engine_core.sv]
// ============================================================================
// sorted_array_engine_core: sorted store of signed 32-bit values
// Add, remove and bisection search over up to CAPACITY entries kept in a
// RAM, in ascending or descending order.
// ============================================================================
//
//  Channel   Dir  Handshake      Item contents
//  cfg       in   valid/ready    descending (order select)
//  req       in   valid/ready    cmd, value
//  rsp       out  valid/ready    status, position, count
//
//  Add and remove run a linear pass that visits one entry per cycle; a full
//  add or a remove on an empty store skips the pass. Search runs bisection
//  steps and ends early on a hit. A new item is accepted once the previous
//  one has reached the result register; a result waiting on rsp blocks only
//  the next result.
//  After reset the store is empty and ascending; cfg is always ready.
//
module sorted_array_engine_core (
    input logic       clk,
    input logic       rst_n,
    sae_cfg_if.sink   cfg,
    sae_req_if.sink   req,
    sae_rsp_if.source rsp
);

    sae_pkg::sae_dp_cmd_t dp_cmd;
    sae_pkg::sae_dp_sts_t dp_sts;

    // Order register is always writable
    assign cfg.ready = 1'b1;

    // Controller
    sae_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (dp_sts),
        .cmd       (dp_cmd)
    );

    // Datapath
    sae_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg.valid),
        .cfg_descending (cfg.descending),
        .req_cmd        (req.cmd),
        .req_value      (req.value),
        .cmd            (dp_cmd),
        .sts            (dp_sts),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .rsp_status     (rsp.status),
        .rsp_position   (rsp.position),
        .rsp_count      (rsp.count)
    );

`ifndef NO_ASSERTIONS
    // An accepted item closes the request side until it has been worked off.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while an item was at work");

    // The reported count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.count <= sae_pkg::COUNT_W'(sae_pkg::CAPACITY)))
        else $error("result count beyond capacity");

    // An error result carries position zero.
    a_error_position: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != sae_pkg::ST_OK)) |-> (rsp.position == '0))
        else $error("error result with nonzero position");

    // A result is only loaded when the result register is free.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.res_load |-> (!rsp.valid || rsp.ready))
        else $error("result register overwritten before it was taken");
`endif

endmodule

[rtl/sae_ram.sv]
// ============================================================================
// sae_ram: generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ============================================================================
module sae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/sae_ctrl.sv]
// ============================================================================
// sae_ctrl: controller of the sorted array engine
// Sequences dispatch, the linear insert/remove pass, bisection and the
// hand-off of the result item.
// ============================================================================
module sae_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  sae_pkg::sae_dp_sts_t sts,
    output sae_pkg::sae_dp_cmd_t cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_ADD      = 3'd2;
    localparam logic [2:0] S_REMOVE   = 3'd3;
    localparam logic [2:0] S_SRCH_RD  = 3'd4;
    localparam logic [2:0] S_SRCH_CMP = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign req_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.cmd)
                    sae_pkg::CMD_ADD:    state_next = sts.full ? S_FINISH : S_ADD;
                    sae_pkg::CMD_REMOVE: state_next = sts.empty ? S_FINISH : S_REMOVE;
                    sae_pkg::CMD_SEARCH: state_next = S_SRCH_RD;
                    default:             state_next = S_FINISH;
                endcase
            end
            S_ADD, S_REMOVE:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SRCH_RD:
            begin
                if (sts.srch_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                cmd.srch_cmp = 1'b1;
                state_next   = sts.srch_hit ? S_FINISH : S_SRCH_RD;
            end
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/sae_dpath.sv]
// ============================================================================
// sae_dpath: datapath of the sorted array engine
// Entry RAM, count, order register, scan and bisection registers, and the
// result register.
// ============================================================================
module sae_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic                        cfg_descending,
    input  logic [1:0]                  req_cmd,
    input  logic signed [31:0]          req_value,
    input  sae_pkg::sae_dp_cmd_t        cmd,
    output sae_pkg::sae_dp_sts_t        sts,
    input  logic                        rsp_ready,
    output logic                        rsp_valid,
    output logic [1:0]                  rsp_status,
    output logic [sae_pkg::POS_W-1:0]   rsp_position,
    output logic [sae_pkg::COUNT_W-1:0] rsp_count
);

    // Control registers
    logic                        descending_reg;
    logic [sae_pkg::CNT_W-1:0]   fill_reg;
    logic [sae_pkg::CNT_W-1:0]   fill_next;
    logic                        out_valid_reg;
    logic                        rd_pend_reg;
    logic                        rd_pend_next;

    // Item and work registers
    logic [1:0]                  cmd_reg;
    logic signed [31:0]          value_reg;
    logic                        full_reg;
    logic                        flag_reg;
    logic                        flag_next;
    logic [sae_pkg::CNT_W-1:0]   idx_reg;
    logic [sae_pkg::CNT_W-1:0]   idx_next;
    logic [sae_pkg::CNT_W-1:0]   rd_idx_reg;
    logic [sae_pkg::CNT_W-1:0]   pos_reg;
    logic [sae_pkg::CNT_W-1:0]   pos_next;
    logic signed [31:0]          hold_reg;
    logic signed [31:0]          hold_next;
    logic [sae_pkg::CNT_W-1:0]   lo_reg;
    logic [sae_pkg::CNT_W-1:0]   lo_next;
    logic [sae_pkg::CNT_W-1:0]   hi_reg;
    logic [sae_pkg::CNT_W-1:0]   hi_next;
    logic [sae_pkg::CNT_W-1:0]   mid_reg;
    logic [sae_pkg::CNT_W-1:0]   mid;
    logic [sae_pkg::CNT_W:0]     mid_sum;

    // Result registers
    logic [1:0]                  status_reg;
    logic [1:0]                  status_next;
    logic [sae_pkg::POS_W-1:0]   position_reg;
    logic [sae_pkg::COUNT_W-1:0] count_reg;

    // RAM port signals
    logic                        ram_we;
    logic [sae_pkg::IDX_W-1:0]   ram_waddr;
    logic signed [31:0]          ram_wdata;
    logic [sae_pkg::IDX_W-1:0]   ram_raddr;
    logic signed [31:0]          ram_rdata;

    // Scan helpers
    logic [sae_pkg::CNT_W-1:0]   last_slot;
    logic [sae_pkg::CNT_W-1:0]   rd_idx_dec;
    logic                        issue;
    logic                        past;
    logic                        equal;

    sae_ram #(
        .WIDTH (sae_pkg::DATA_W),
        .DEPTH (sae_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Order test and equality on the entry that the RAM returns
    assign past  = descending_reg ? (ram_rdata <= value_reg) : (ram_rdata >= value_reg);
    assign equal = (ram_rdata == value_reg);

    // The add pass visits one slot past the stored entries; remove stops at the last one
    assign last_slot  = (cmd_reg == sae_pkg::CMD_ADD) ? fill_reg
                                                      : fill_reg - sae_pkg::CNT_W'(1);
    assign issue      = (idx_reg <= last_slot);
    assign rd_idx_dec = rd_idx_reg - sae_pkg::CNT_W'(1);

    // Floor midpoint of the range [lo, hi)
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - (sae_pkg::CNT_W + 1)'(1);
    assign mid     = mid_sum[sae_pkg::CNT_W:1];

    // Status toward the controller
    assign sts.cmd       = cmd_reg;
    assign sts.full      = full_reg;
    assign sts.empty     = (fill_reg == '0);
    assign sts.scan_last = rd_pend_reg && (rd_idx_reg == last_slot);
    assign sts.srch_done = (lo_reg >= hi_reg);
    assign sts.srch_hit  = equal;
    assign sts.out_busy  = out_valid_reg && !rsp_ready;

    // Scan and bisection step logic
    always_comb
    begin
        ram_we       = 1'b0;
        ram_waddr    = rd_idx_reg[sae_pkg::IDX_W-1:0];
        ram_wdata    = value_reg;
        ram_raddr    = idx_reg[sae_pkg::IDX_W-1:0];
        idx_next     = idx_reg;
        rd_pend_next = 1'b0;
        flag_next    = flag_reg;
        pos_next     = pos_reg;
        hold_next    = hold_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        if (cmd.scan)
        begin
            // Read the next slot while the previous one is handled
            if (issue)
            begin
                rd_pend_next = 1'b1;
                idx_next     = idx_reg + sae_pkg::CNT_W'(1);
            end
            if (rd_pend_reg)
            begin
                if (cmd_reg == sae_pkg::CMD_ADD)
                begin
                    if (!flag_reg && ((rd_idx_reg == fill_reg) || past))
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = value_reg;
                        hold_next = ram_rdata;
                        flag_next = 1'b1;
                        pos_next  = rd_idx_reg;
                    end
                    else if (flag_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = hold_reg;
                        hold_next = ram_rdata;
                    end
                end
                else
                begin
                    if (!flag_reg && equal)
                    begin
                        flag_next = 1'b1;
                        pos_next  = rd_idx_reg;
                    end
                    else if (flag_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = rd_idx_dec[sae_pkg::IDX_W-1:0];
                        ram_wdata = ram_rdata;
                    end
                end
            end
        end
        if (cmd.srch_rd)
        begin
            ram_raddr = mid[sae_pkg::IDX_W-1:0];
        end
        if (cmd.srch_cmp)
        begin
            if (equal)
            begin
                flag_next = 1'b1;
                pos_next  = mid_reg;
            end
            else if (past)
            begin
                hi_next = mid_reg;
            end
            else
            begin
                lo_next = mid_reg + sae_pkg::CNT_W'(1);
            end
        end
    end

    // Result status and count after the command
    always_comb
    begin
        fill_next = fill_reg;
        case (cmd_reg)
            sae_pkg::CMD_ADD:
            begin
                status_next = full_reg ? sae_pkg::ST_FULL : sae_pkg::ST_OK;
                if (!full_reg)
                begin
                    fill_next = fill_reg + sae_pkg::CNT_W'(1);
                end
            end
            sae_pkg::CMD_REMOVE:
            begin
                status_next = flag_reg ? sae_pkg::ST_OK : sae_pkg::ST_MISSING;
                if (flag_reg)
                begin
                    fill_next = fill_reg - sae_pkg::CNT_W'(1);
                end
            end
            sae_pkg::CMD_SEARCH:
            begin
                status_next = flag_reg ? sae_pkg::ST_OK : sae_pkg::ST_MISSING;
            end
            default:
            begin
                status_next = sae_pkg::ST_OK;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            descending_reg <= 1'b0;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
            rd_pend_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                descending_reg <= cfg_descending;
            end
            if (cmd.res_load)
            begin
                fill_reg <= fill_next;
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            rd_pend_reg <= rd_pend_next;
        end
    end

    // Item, work and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= req_cmd;
            value_reg <= req_value;
            full_reg  <= (fill_reg == sae_pkg::CNT_W'(sae_pkg::CAPACITY));
            flag_reg  <= 1'b0;
            pos_reg   <= '0;
            idx_reg   <= '0;
            lo_reg    <= '0;
            hi_reg    <= fill_reg;
        end
        else
        begin
            flag_reg <= flag_next;
            pos_reg  <= pos_next;
            idx_reg  <= idx_next;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
        end
        hold_reg   <= hold_next;
        rd_idx_reg <= idx_reg;
        if (cmd.srch_rd)
        begin
            mid_reg <= mid;
        end
        if (cmd.res_load)
        begin
            status_reg   <= status_next;
            position_reg <= sae_pkg::POS_W'(pos_reg);
            count_reg    <= sae_pkg::COUNT_W'(fill_next);
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign rsp_status   = status_reg;
    assign rsp_position = position_reg;
    assign rsp_count    = count_reg;

endmodule

[tb/testbench.sv]
// ============================================================================
// testbench: self-checking bench for sorted_array_engine_core
// Drives add, remove and search items with bursty valid and a stalling
// response side, predicts every result from a local copy of the sorted store,
// and compares status, position and count item by item.
// ============================================================================
module testbench;

    import sae_pkg::*;

    // The encoding that the block answers without touching the store
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Cycle limit for the whole run
    localparam int CYCLE_LIMIT = 600000;

    // Receiver hold-off used to back the engine up
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        logic [1:0]         status;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
    } sort_result_t;

    // Scoreboard: a local sorted store that predicts each result, plus the
    // queue of results still owed by the block.
    class sorted_store_scoreboard;
        logic signed [DATA_W-1:0] entries [CAPACITY];
        int                       fill = 0;
        bit                       descending = 1'b0;
        sort_result_t             owed_q [$];
        int                       errors = 0;
        int                       checked = 0;

        function int pending();
            return owed_q.size();
        endfunction

        function void set_order(bit desc);
            descending = desc;
        endfunction

        // True when a stored entry sits at or past the operand in the order.
        function bit at_or_past(logic signed [DATA_W-1:0] a,
                                logic signed [DATA_W-1:0] d);
            return descending ? (a <= d) : (a >= d);
        endfunction

        // Apply one accepted item to the store and queue its result.
        function void note_item(logic [1:0] cmd, logic signed [DATA_W-1:0] value);
            sort_result_t r;
            int           pos;
            int           i;
            int           lo;
            int           hi;
            int           mid;
            bit           hit;
            r.status = ST_OK;
            pos = 0;
            hit = 1'b0;
            case (cmd)
                CMD_ADD:
                begin
                    if (fill >= CAPACITY) begin
                        r.status = ST_FULL;
                    end
                    else begin
                        pos = fill;
                        for (i = 0; i < fill; i++) begin
                            if (at_or_past(entries[i], value)) begin
                                pos = i;
                                break;
                            end
                        end
                        for (i = fill; i > pos; i--)
                            entries[i] = entries[i - 1];
                        entries[pos] = value;
                        fill++;
                    end
                end
                CMD_REMOVE:
                begin
                    for (i = 0; i < fill; i++) begin
                        if (entries[i] == value) begin
                            pos = i;
                            hit = 1'b1;
                            break;
                        end
                    end
                    if (hit) begin
                        for (i = pos; i + 1 < fill; i++)
                            entries[i] = entries[i + 1];
                        fill--;
                    end
                    else begin
                        r.status = ST_MISSING;
                    end
                end
                CMD_SEARCH:
                begin
                    // Floor-midpoint bisection; first equal entry met wins.
                    lo = 0;
                    hi = fill - 1;
                    while (hi >= lo) begin
                        mid = lo + (hi - lo) / 2;
                        if (entries[mid] == value) begin
                            pos = mid;
                            hit = 1'b1;
                            break;
                        end
                        if (at_or_past(entries[mid], value))
                            hi = mid - 1;
                        else
                            lo = mid + 1;
                    end
                    if (!hit)
                        r.status = ST_MISSING;
                end
                default:
                begin
                end
            endcase
            r.position = pos[POS_W-1:0];
            r.count    = fill[COUNT_W-1:0];
            owed_q.push_back(r);
        endfunction

        // Print one mismatch line and count it.
        task report(string msg);
            errors++;
            $display("mismatch at result %0d: %s", checked, msg);
        endtask

        // Compare one accepted result with the oldest owed result.
        task check_result(logic [1:0] status, logic [POS_W-1:0] position,
                          logic [COUNT_W-1:0] count);
            sort_result_t exp_r;
            if (owed_q.size() == 0) begin
                report($sformatf("unexpected result status=%0d position=%0d count=%0d",
                                 status, position, count));
            end
            else begin
                exp_r = owed_q.pop_front();
                if (status !== exp_r.status)
                    report($sformatf("status %0d, predicted %0d", status, exp_r.status));
                if (position !== exp_r.position)
                    report($sformatf("position %0d, predicted %0d",
                                     position, exp_r.position));
                if (count !== exp_r.count)
                    report($sformatf("count %0d, predicted %0d", count, exp_r.count));
            end
            checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;

    sae_cfg_if cfg_ch ();
    sae_req_if req_ch ();
    sae_rsp_if rsp_ch ();

    sorted_array_engine_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    sorted_store_scoreboard sb;

    int burst_left = 0;
    int hold_requests = 0;
    int cycle_count = 0;

    // Clock with a period of two time units
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Monitor: results are checked before the same edge's item is noted.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.status, rsp_ch.position, rsp_ch.count);
            if (cfg_ch.valid && cfg_ch.ready)
                sb.set_order(cfg_ch.descending);
            if (req_ch.valid && req_ch.ready)
                sb.note_item(req_ch.cmd, req_ch.value);
        end
    end

    // Receiver: stalls in random stretches, plus long hold-offs on request.
    initial
    begin
        int  hold_left;
        int  holds_served;
        int  mode;
        int  mode_left;
        bit  rdy;
        hold_left = 0;
        holds_served = 0;
        mode = 0;
        mode_left = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_requests != holds_served) begin
                hold_left = LONG_HOLD;
                holds_served = hold_requests;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end
            else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(5, 60);
                end
                mode_left--;
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = $urandom_range(0, 1);
                    default: rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            rsp_ch.ready <= rdy;
        end
    end

    // Run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    // Offer one item, starting a new burst after a random gap when the
    // current burst is used up. Returns at the falling edge after accept.
    task automatic send_item(logic [1:0] cmd, logic signed [DATA_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= cmd;
        req_ch.value <= value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        burst_left--;
    endtask

    // Stop offering items until every owed result has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (sb.pending() > 0);
    endtask

    // Write the order register once the engine is idle.
    task automatic write_order(bit desc);
        wait_drained();
        repeat (3) @(negedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.descending <= desc;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Operand mix: stored entries for hits, a small pool for duplicates,
    // the range extremes, and fully random values.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int sel;
        int k;
        sel = $urandom_range(0, 99);
        if (sel < 25 && sb.fill > 0)
            return sb.entries[$urandom_range(0, sb.fill - 1)];
        if (sel < 60) begin
            k = $urandom_range(0, 15);
            return k - 8;
        end
        if (sel < 70) begin
            case ($urandom_range(0, 5))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7FFF_FFFF;
                2:       return 32'sh8000_0001;
                3:       return 32'sh7FFF_FFFE;
                4:       return -32'sd1;
                default: return 32'sd0;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_cmd(int add_w, int rem_w, int srch_w);
        int r;
        r = $urandom_range(0, 99);
        if (r < add_w)
            return CMD_ADD;
        if (r < add_w + rem_w)
            return CMD_REMOVE;
        if (r < add_w + rem_w + srch_w)
            return CMD_SEARCH;
        return CMD_UNUSED;
    endfunction

    // Main sequence
    initial
    begin
        int phase;
        int n;
        int add_w;
        int rem_w;
        int srch_w;
        sb = new;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_ADD;
        req_ch.value = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.descending = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty store, extremes, duplicates, hits and misses
        // in the reset order (ascending).
        send_item(CMD_SEARCH, 32'sd5);
        send_item(CMD_REMOVE, 32'sd5);
        send_item(CMD_ADD, 32'sd0);
        send_item(CMD_ADD, 32'sh7FFF_FFFF);
        send_item(CMD_ADD, 32'sh8000_0000);
        send_item(CMD_ADD, -32'sd1);
        send_item(CMD_ADD, 32'sd0);
        send_item(CMD_ADD, 32'sd1);
        send_item(CMD_SEARCH, 32'sd0);
        send_item(CMD_SEARCH, 32'sh7FFF_FFFF);
        send_item(CMD_SEARCH, 32'sh8000_0000);
        send_item(CMD_SEARCH, 32'sd7);
        send_item(CMD_REMOVE, 32'sd0);
        send_item(CMD_REMOVE, 32'sh7FFF_FFFF);
        send_item(CMD_REMOVE, 32'sd99);
        send_item(CMD_UNUSED, 32'sd0);

        // Directed: flip the order with entries stored; they stay as they are.
        write_order(1'b1);
        send_item(CMD_ADD, 32'sd5);
        send_item(CMD_SEARCH, -32'sd1);
        send_item(CMD_SEARCH, 32'sd1);
        send_item(CMD_REMOVE, 32'sh8000_0000);
        send_item(CMD_UNUSED, -32'sd1);

        // Random phases: the order alternates and the command mix rotates
        // between filling up, balanced, draining and search-heavy.
        for (phase = 0; phase < 10; phase++) begin
            write_order(phase[0]);
            case (phase % 4)
                0:       begin add_w = 65; rem_w = 15; srch_w = 17; end
                1:       begin add_w = 40; rem_w = 30; srch_w = 27; end
                2:       begin add_w = 15; rem_w = 60; srch_w = 22; end
                default: begin add_w = 30; rem_w = 20; srch_w = 47; end
            endcase
            for (n = 0; n < 190; n++) begin
                // Back the engine up with a long receiver hold-off.
                if (phase == 0 && n == 60)
                    hold_requests++;
                // Pause the sender until every owed result is back.
                if (n == 120)
                    wait_drained();
                send_item(pick_cmd(add_w, rem_w, srch_w), pick_value());
            end
        end

        // Drain and let the engine settle.
        req_ch.valid <= 1'b0;
        while (sb.pending() > 0)
            @(negedge clk);
        repeat (60) @(negedge clk);

        if (sb.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

[sim.f]
rtl/sae_pkg.sv
rtl/sae_if.sv
rtl/sae_ram.sv
rtl/sae_ctrl.sv
rtl/sae_dpath.sv
rtl/sorted_array_engine_core.sv
tb/testbench.sv
